@@ rtl/receive_loss_list_macros.svh @@
// Assertion macros for the receive loss list module.
`ifndef RECEIVE_LOSS_LIST_MACROS_SVH
`define RECEIVE_LOSS_LIST_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define RLL_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the next cycle.
`define RLL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/rll_pkg.sv @@
package rll_pkg;

  localparam int unsigned SeqW = 31;
  localparam int unsigned TimeW = 64;
  localparam int unsigned CountW = 8;
  localparam int unsigned IvalW = 31;
  localparam int unsigned DefaultCapacity = 64;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_MUL,
    S_CMP,
    S_EMIT,
    S_DONE
  } state_t;

  // One entry as it moves along the chain.
  typedef struct packed {
    logic [SeqW-1:0]   seq;
    logic [TimeW-1:0]  tstamp;
    logic [CountW-1:0] count;
  } entry_t;

  // Command from the controller to every cell of the chain.
  typedef struct packed {
    logic rotate;      // every cell takes its upper neighbour's entry
    logic write0;      // head cell takes the refreshed entry
    logic write_tail;  // the slot just past the occupied region takes a new entry
    entry_t wdata;
  } chain_cmd_t;

  // Wrap-aware order key: 32 bits, top bit set for the low group.
  function automatic logic [SeqW:0] order_key(input logic [SeqW-1:0] s,
                                              input logic [SeqW-1:0] left,
                                              input logic wrapped);
    order_key = (!wrapped || s > left) ? {1'b0, s} : {1'b1, s};
  endfunction

  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
    bump = (c == CountMax) ? c : c + 1'b1;
  endfunction

endpackage

@@ rtl/rll_cell.sv @@
// One slot of the circular entry chain.
module rll_cell (
  input  logic                clk,
  input  logic                wr,
  input  rll_pkg::chain_cmd_t cmd,
  input  rll_pkg::entry_t     from_up,
  output rll_pkg::entry_t     held
);

  rll_pkg::entry_t ent;

  always_ff @(posedge clk) begin
    if (wr) begin
      ent <= cmd.wdata;
    end else if (cmd.rotate) begin
      ent <= from_up;
    end
  end

  assign held = ent;

endmodule

@@ rtl/rll_chain.sv @@
// Ring of cells. On rotate each cell takes the entry of the cell above it
// and the head entry moves to the tail slot of the occupied region, which
// the controller keeps at index fill-1 through the wrap select.
module rll_chain #(
  parameter int unsigned Capacity = rll_pkg::DefaultCapacity
) (
  input  logic                        clk,
  input  rll_pkg::chain_cmd_t         cmd,
  input  logic [$clog2(Capacity+1)-1:0] fill,
  output rll_pkg::entry_t             head
);

  rll_pkg::entry_t cells [Capacity];
  rll_pkg::entry_t feed  [Capacity];

  // Each cell takes the one above it; the last occupied slot takes the head.
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      if (i == Capacity - 1) begin
        feed[i] = cells[0];
      end else if (32'(i) + 1 == 32'(fill)) begin
        feed[i] = cells[0];
      end else begin
        feed[i] = cells[i+1];
      end
    end
  end

  // A new entry lands in the slot just past the occupied region, which in
  // ring order lies between the entry last rotated away and the head.
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    rll_cell u_cell (
      .clk     (clk),
      .wr      (((g == 0) && cmd.write0) || ((32'(g) == 32'(fill)) && cmd.write_tail)),
      .cmd     (cmd),
      .from_up (feed[g]),
      .held    (cells[g])
    );
  end

  assign head = cells[0];

endmodule

@@ rtl/receive_loss_list.sv @@
// Receive loss list.
// Input channel: in_valid/in_ready carry one item (mode, seq_number,
// feedback_time, window edges, current_time, nak_interval). Output channel:
// out_valid/out_ready carry result items; the last result of an item has
// last set. Add and remove give one result, a scan gives one result per
// timed-out entry (or a single result without a report).
// The entries sit in a ring of cells that rotates by one place per cycle
// while told to, and every operation turns the ring once, so the first
// entry is back at the head when it finishes. An add or remove walks the
// ring in the walk state, then offers its result in the done state. A scan
// takes each entry through a multiply and a compare state, and each
// timed-out entry also through an emit state; each report is held back
// until the next one is found, so that the final report can carry last. A
// new item is taken no earlier than the cycle after the last result of the
// current one has been taken. Reset clears the fill count and sets
// initial_count to 1; the cells hold no reset value. A stalled receiver
// holds the block with its result steady. The user writes initial_count with
// cfg_we/cfg_data only while the block is idle; the block doesn't enforce it.
`include "receive_loss_list_macros.svh"
module receive_loss_list #(
  parameter int unsigned Capacity = rll_pkg::DefaultCapacity
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [30:0] seq_number,
  input  logic [63:0] feedback_time,
  input  logic [30:0] window_left,
  input  logic [30:0] window_right,
  input  logic [63:0] current_time,
  input  logic [30:0] nak_interval,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] reported_seq,
  output logic        report_valid,
  output logic        last,
  output logic [1:0]  status,
  output logic        list_empty,
  output logic [30:0] first_seq,
  output logic [6:0]  entry_count
);

  localparam int unsigned FillW = $clog2(Capacity + 1);

  rll_pkg::state_t state, state_next;
  logic [FillW-1:0] fill, fill_next;
  logic [FillW-1:0] idx, idx_next;      // entries already passed in this turn
  logic [7:0] init_count;
  logic       done_flag, done_next;     // add/remove located its place
  logic       any_rep, any_rep_next;    // a scan report is waiting in pend_seq
  logic       pend_load;
  rll_pkg::status_t st, st_next;

  // Latched item.
  rll_pkg::mode_t   op;
  logic [30:0]      seq_q, left_q;
  logic             wrapped_q;
  logic [63:0]      fb_q, now_q;
  logic [30:0]      ival_q;
  logic [30:0]      first_q;

  // Scan pipeline: product register and the report held back.
  logic [38:0] prod;
  logic        expired;
  logic [30:0] pend_seq;

  rll_pkg::entry_t    head;
  rll_pkg::chain_cmd_t cmd;
  logic [FillW-1:0] fill_q_out;

  rll_chain #(.Capacity(Capacity)) u_chain (
    .clk  (clk),
    .cmd  (cmd),
    .fill (fill),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      init_count <= 8'd1;
    end else if (cfg_we) begin
      init_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op        <= rll_pkg::mode_t'(mode);
      seq_q     <= seq_number;
      fb_q      <= feedback_time;
      left_q    <= window_left;
      wrapped_q <= !(window_left < window_right);
      now_q     <= current_time;
      ival_q    <= nak_interval;
      first_q   <= head.seq;
    end
    if (pend_load) begin
      pend_seq <= head.seq;
    end
    prod <= 39'(head.count) * 39'(ival_q);
  end

  // Deadline check on the product registered in the multiply cycle; the
  // head does not move between the multiply and the compare cycle.
  logic [64:0] deadline;
  assign deadline = {1'b0, head.tstamp} + 65'(prod);
  assign expired  = !deadline[64] && (deadline[63:0] < now_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rll_pkg::S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
    idx       <= idx_next;
    done_flag <= done_next;
    any_rep   <= any_rep_next;
    st        <= st_next;
  end

  logic at_end;
  logic [31:0] key_new, key_head;
  assign at_end   = (idx == fill);
  assign key_new  = rll_pkg::order_key(seq_q, left_q, wrapped_q);
  assign key_head = rll_pkg::order_key(head.seq, left_q, wrapped_q);

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    idx_next     = idx;
    done_next    = done_flag;
    any_rep_next = any_rep;
    st_next      = st;
    pend_load    = 1'b0;
    cmd          = '0;
    cmd.wdata    = head;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    report_valid = 1'b0;
    last         = 1'b0;
    fill_q_out   = fill;
    unique case (state)
      rll_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          idx_next     = '0;
          done_next    = 1'b0;
          any_rep_next = 1'b0;
          st_next      = rll_pkg::ST_OK;
          state_next   = (rll_pkg::mode_t'(mode) == rll_pkg::MODE_SCAN) ?
                         ((fill == '0) ? rll_pkg::S_DONE : rll_pkg::S_MUL) :
                         rll_pkg::S_WALK;
          if (rll_pkg::mode_t'(mode) == rll_pkg::MODE_SCAN && fill == '0) begin
            st_next = rll_pkg::ST_EMPTY;
          end
        end
      end
      rll_pkg::S_WALK: begin
        // Head holds entry idx of the sorted table.
        if (op == rll_pkg::MODE_ADD) begin
          if (done_flag) begin
            if (at_end) begin
              state_next = rll_pkg::S_DONE;
            end else begin
              cmd.rotate = 1'b1;
              idx_next   = idx + 1'b1;
            end
          end else if (!at_end && head.seq == seq_q) begin
            cmd.write0 = 1'b1;
            cmd.wdata  = '{seq: head.seq, tstamp: fb_q,
                           count: rll_pkg::bump(head.count)};
            done_next  = 1'b1;
          end else if (at_end || key_new < key_head) begin
            done_next = 1'b1;
            if (fill == FillW'(Capacity)) begin
              st_next = rll_pkg::ST_FULL;
            end else begin
              // The new entry goes in just behind the occupied region, which
              // in ring order places it before the head. It counts as passed.
              cmd.write_tail = 1'b1;
              cmd.wdata      = '{seq: seq_q, tstamp: fb_q, count: init_count};
              fill_next      = fill + 1'b1;
              idx_next       = idx + 1'b1;
            end
          end else begin
            cmd.rotate = 1'b1;
            idx_next   = idx + 1'b1;
          end
        end else if (op == rll_pkg::MODE_REMOVE) begin
          if (at_end) begin
            if (!done_flag) st_next = rll_pkg::ST_NOT_FOUND;
            state_next = rll_pkg::S_DONE;
          end else if (!done_flag && head.seq == seq_q) begin
            // Rotating while the ring shrinks leaves the head outside it.
            cmd.rotate = 1'b1;
            done_next  = 1'b1;
            fill_next  = fill - 1'b1;
          end else begin
            cmd.rotate = 1'b1;
            idx_next   = idx + 1'b1;
          end
        end else begin
          state_next = rll_pkg::S_DONE;
        end
      end
      rll_pkg::S_EMIT: begin
        // The refreshed entry is at the head. A report still waiting goes out
        // first; then this entry becomes the waiting report.
        if (any_rep) begin
          out_valid    = 1'b1;
          report_valid = 1'b1;
          if (out_ready) begin
            pend_load  = 1'b1;
            cmd.rotate = 1'b1;
            idx_next   = idx + 1'b1;
            state_next = rll_pkg::S_MUL;
          end
        end else begin
          pend_load    = 1'b1;
          any_rep_next = 1'b1;
          cmd.rotate   = 1'b1;
          idx_next     = idx + 1'b1;
          state_next   = rll_pkg::S_MUL;
        end
      end
      rll_pkg::S_MUL: begin
        if (at_end) state_next = rll_pkg::S_DONE;
        else state_next = rll_pkg::S_CMP;
      end
      rll_pkg::S_CMP: begin
        if (expired) begin
          cmd.write0 = 1'b1;
          cmd.wdata  = '{seq: head.seq, tstamp: fb_q,
                         count: rll_pkg::bump(head.count)};
          state_next = rll_pkg::S_EMIT;
        end else begin
          cmd.rotate = 1'b1;
          idx_next   = idx + 1'b1;
          state_next = rll_pkg::S_MUL;
        end
      end
      rll_pkg::S_DONE: begin
        // Final result: the last scan report, or a result without a report.
        out_valid    = 1'b1;
        last         = 1'b1;
        report_valid = any_rep;
        if (out_ready) state_next = rll_pkg::S_IDLE;
      end
      default: state_next = rll_pkg::S_IDLE;
    endcase
  end

  assign reported_seq = report_valid ? pend_seq : '0;
  assign status       = st;
  assign list_empty   = (fill_q_out == '0);
  assign first_seq    = (fill_q_out == '0) ? '0 :
                        (op == rll_pkg::MODE_SCAN) ? first_q : head.seq;
  assign entry_count  = 7'(fill_q_out);

  `RLL_ASSERT(a_fill_cap, clk, rst, 1'b1, fill <= FillW'(Capacity), "fill above capacity")
  `RLL_ASSERT(a_ready_idle, clk, rst, in_ready, state == rll_pkg::S_IDLE, "ready outside idle")
  `RLL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")

endmodule
